/* rtl/cls_pkg.sv */
// ----------------------------------------------------------------------------
// cls_pkg: shared types and constants for the command line splitter
// Payload structs, controller/datapath command and status, character codes.
// ----------------------------------------------------------------------------
package cls_pkg;

  localparam int HOLD_DEPTH_DEF = 32;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // held whitespace codes
  localparam logic [1:0] HC_SPACE = 2'd0;
  localparam logic [1:0] HC_TAB   = 2'd1;
  localparam logic [1:0] HC_NL    = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } text_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       command_done;
    logic       ws_overflow;
    logic       run_last;
  } cmd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_HELD,
    ST_EMIT_HELD,
    ST_BYTE_A,
    ST_BYTE_B,
    ST_MARK
  } cls_state_t;

  typedef enum logic [1:0] {
    SEL_HELD,
    SEL_A,
    SEL_B,
    SEL_MARK
  } out_sel_t;

  // what one item produces, in output order
  typedef struct packed {
    logic rel;   // held whitespace to release first
    logic a;
    logic b;
    logic mk;    // end marker
  } plan_t;

  typedef struct packed {
    logic     accept;
    logic     rd_en;
    logic     idx_inc;
    logic     load_out;
    out_sel_t out_sel;
    logic     out_last;
    logic     wr_ok;
  } cls_cmd_t;

  typedef struct packed {
    plan_t plan_now;
    plan_t plan_r;
    logic  idx_last;
    logic  out_free;
  } cls_status_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  function automatic logic [1:0] ws_code(input logic [7:0] c);
    logic [1:0] r;
    if (c == CH_SPACE) begin
      r = HC_SPACE;
    end else if (c == CH_TAB) begin
      r = HC_TAB;
    end else begin
      r = HC_NL;
    end
    return r;
  endfunction

  function automatic logic [7:0] code_to_char(input logic [1:0] code);
    logic [7:0] r;
    unique case (code)
      HC_TAB:  r = CH_TAB;
      HC_NL:   r = CH_NL;
      default: r = CH_SPACE;
    endcase
    return r;
  endfunction

endpackage

/* rtl/cls_ram.sv */
// ----------------------------------------------------------------------------
// cls_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cls_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/cls_ctrl.sv */
// ----------------------------------------------------------------------------
// cls_ctrl: sequencer for the command line splitter
// Accepts a byte in idle, then steps through held whitespace, bytes, marker.
// ----------------------------------------------------------------------------
module cls_ctrl
  import cls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  cls_status_t sts,
  output cls_cmd_t    cmd
);

  cls_state_t state_r, state_nxt;

  function automatic cls_state_t step_from(input plan_t p, input logic from_held);
    cls_state_t s;
    priority if (p.rel && !from_held) begin
      s = ST_RD_HELD;
    end else if (p.a) begin
      s = ST_BYTE_A;
    end else if (p.b) begin
      s = ST_BYTE_B;
    end else if (p.mk) begin
      s = ST_MARK;
    end else begin
      s = ST_IDLE;
    end
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = step_from(sts.plan_now, 1'b0);
        end
      end
      ST_RD_HELD: state_nxt = ST_EMIT_HELD;
      ST_EMIT_HELD: begin
        if (sts.out_free) begin
          state_nxt = sts.idx_last ? step_from(sts.plan_r, 1'b1) : ST_RD_HELD;
        end
      end
      ST_BYTE_A: begin
        if (sts.out_free) begin
          state_nxt = sts.plan_r.b ? ST_BYTE_B : (sts.plan_r.mk ? ST_MARK : ST_IDLE);
        end
      end
      ST_BYTE_B: begin
        if (sts.out_free) begin
          state_nxt = sts.plan_r.mk ? ST_MARK : ST_IDLE;
        end
      end
      ST_MARK: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.out_sel  = SEL_HELD;
    cmd.wr_ok    = 1'b1;
    in_stall     = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_RD_HELD: begin
        cmd.rd_en = 1'b1;
        cmd.wr_ok = 1'b0;
      end
      ST_EMIT_HELD: begin
        cmd.wr_ok    = 1'b0;
        cmd.out_sel  = SEL_HELD;
        cmd.load_out = sts.out_free;
        cmd.idx_inc  = sts.out_free;
      end
      ST_BYTE_A: begin
        cmd.out_sel  = SEL_A;
        cmd.load_out = sts.out_free;
        cmd.out_last = !sts.plan_r.b && !sts.plan_r.mk;
      end
      ST_BYTE_B: begin
        cmd.out_sel  = SEL_B;
        cmd.load_out = sts.out_free;
        cmd.out_last = !sts.plan_r.mk;
      end
      ST_MARK: begin
        cmd.out_sel  = SEL_MARK;
        cmd.load_out = sts.out_free;
        cmd.out_last = 1'b1;
      end
      default: begin
        cmd.wr_ok = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/cls_datapath.sv */
// ----------------------------------------------------------------------------
// cls_datapath: byte decode, splitter state, hold buffer and output register
// Decodes one accepted byte into a result plan and updates the parse state.
// ----------------------------------------------------------------------------
module cls_datapath
  import cls_pkg::*;
#(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  text_in_t    in_data,
  input  cls_cmd_t    cmd,
  output cls_status_t sts,
  input  logic        out_stall,
  output logic        out_valid,
  output cmd_out_t    out_data
);

  localparam int CNT_W = $clog2(HOLD_DEPTH + 1);
  localparam int IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  // parse state
  logic             quote_r, comment_r, slash_r, started_r, ovf_r;
  logic [CNT_W-1:0] held_cnt_r;

  // plan of the current item
  logic [CNT_W-1:0] rel_n_r;
  logic [7:0]       a_byte_r, b_byte_r;
  logic             a_v_r, b_v_r, mk_v_r, mk_ovf_r;
  logic             wr_pend_r;
  logic [1:0]       wr_code_r;
  logic [IDX_W-1:0] wr_idx_r;
  logic [IDX_W-1:0] idx_r;

  logic             out_valid_r;
  cmd_out_t         out_data_r, out_data_nxt;

  // decode results
  logic             n_q, n_cm, n_sp, n_st, n_ov;
  logic [CNT_W-1:0] n_hc;
  logic [CNT_W-1:0] rel_n;
  logic [7:0]       a_b, b_b;
  logic             a_v, b_v, mk_v, mk_ov;
  logic             wr_v;
  logic [1:0]       wr_code;
  logic [IDX_W-1:0] wr_idx;

  logic [1:0]       ram_rdata;
  logic             ram_we;

  always_comb begin
    logic [7:0] c;
    logic       lst;
    logic       p_keep, p_close, p_sp, p_q;
    logic       k1_v, k2_v, cl;
    logic [7:0] k1, k2;

    c   = in_data.text_byte;
    lst = in_data.text_end;

    // ordinary byte handling outside a comment
    p_keep  = 1'b0;
    p_close = 1'b0;
    p_sp    = 1'b0;
    p_q     = quote_r;
    priority if (!quote_r && c == CH_SLASH) begin
      p_keep = lst;
      p_sp   = !lst;
    end else if (c == CH_QUOTE) begin
      p_q    = !quote_r;
      p_keep = 1'b1;
    end else if (!quote_r && (c == CH_SEMI || c == CH_NL)) begin
      p_close = 1'b1;
    end else begin
      p_keep = (c != CH_CR);
    end

    n_q  = quote_r;
    n_cm = comment_r;
    n_sp = slash_r;
    k1_v = 1'b0;
    k1   = c;
    k2_v = 1'b0;
    k2   = c;
    cl   = 1'b0;
    priority if (comment_r) begin
      if (c == CH_NL) begin
        n_cm = 1'b0;
        cl   = 1'b1;
      end
    end else if (slash_r) begin
      n_sp = 1'b0;
      if (c == CH_SLASH) begin
        n_cm = 1'b1;
      end else begin
        // lone slash goes out ahead of this byte
        k1_v = 1'b1;
        k1   = CH_SLASH;
        k2_v = p_keep;
        cl   = p_close;
        n_q  = p_q;
        n_sp = p_sp;
      end
    end else begin
      k1_v = p_keep;
      cl   = p_close;
      n_q  = p_q;
      n_sp = p_sp;
    end

    n_st    = started_r;
    n_hc    = held_cnt_r;
    n_ov    = ovf_r;
    rel_n   = '0;
    a_v     = 1'b0;
    a_b     = k1;
    b_v     = 1'b0;
    b_b     = k2;
    wr_v    = 1'b0;
    wr_code = HC_SPACE;
    wr_idx  = '0;

    if (k1_v) begin
      if (is_ws(k1)) begin
        if (n_st) begin
          if (n_hc < CNT_W'(HOLD_DEPTH)) begin
            wr_v    = 1'b1;
            wr_idx  = n_hc[IDX_W-1:0];
            wr_code = ws_code(k1);
            n_hc    = n_hc + CNT_W'(1);
          end else begin
            n_ov = 1'b1;
          end
        end
      end else begin
        rel_n = n_st ? n_hc : '0;
        n_hc  = '0;
        a_v   = 1'b1;
        n_st  = 1'b1;
      end
    end

    // second byte only follows a released slash, so the command is open
    if (k2_v) begin
      if (is_ws(k2)) begin
        if (n_hc < CNT_W'(HOLD_DEPTH)) begin
          wr_v    = 1'b1;
          wr_idx  = n_hc[IDX_W-1:0];
          wr_code = ws_code(k2);
          n_hc    = n_hc + CNT_W'(1);
        end else begin
          n_ov = 1'b1;
        end
      end else begin
        n_hc = '0;
        b_v  = 1'b1;
        n_st = 1'b1;
      end
    end

    mk_v  = 1'b0;
    mk_ov = 1'b0;
    if (cl) begin
      mk_v  = n_st;
      mk_ov = n_ov;
      n_st  = 1'b0;
      n_hc  = '0;
      n_ov  = 1'b0;
    end
    if (lst) begin
      if (n_st) begin
        mk_v  = 1'b1;
        mk_ov = n_ov;
      end
      n_st = 1'b0;
      n_hc = '0;
      n_ov = 1'b0;
      n_q  = 1'b0;
      n_cm = 1'b0;
      n_sp = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r    <= 1'b0;
      comment_r  <= 1'b0;
      slash_r    <= 1'b0;
      started_r  <= 1'b0;
      held_cnt_r <= '0;
      ovf_r      <= 1'b0;
      wr_pend_r  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        quote_r    <= n_q;
        comment_r  <= n_cm;
        slash_r    <= n_sp;
        started_r  <= n_st;
        held_cnt_r <= n_hc;
        ovf_r      <= n_ov;
        wr_pend_r  <= wr_v;
      end else if (ram_we) begin
        wr_pend_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rel_n_r  <= rel_n;
      a_byte_r <= a_b;
      b_byte_r <= b_b;
      a_v_r    <= a_v;
      b_v_r    <= b_v;
      mk_v_r   <= mk_v;
      mk_ovf_r <= mk_ov;
      wr_code_r <= wr_code;
      wr_idx_r  <= wr_idx;
      idx_r     <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // new whitespace is written only once the release of older entries is done
  assign ram_we = wr_pend_r && cmd.wr_ok;

  cls_ram #(
    .WIDTH(2),
    .DEPTH(HOLD_DEPTH)
  ) u_held (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx_r),
    .wdata(wr_code_r),
    .re   (cmd.rd_en),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    out_data_nxt              = '0;
    out_data_nxt.run_last     = cmd.out_last;
    unique case (cmd.out_sel)
      SEL_HELD: out_data_nxt.out_byte = code_to_char(ram_rdata);
      SEL_A:    out_data_nxt.out_byte = a_byte_r;
      SEL_B:    out_data_nxt.out_byte = b_byte_r;
      SEL_MARK: begin
        out_data_nxt.command_done = 1'b1;
        out_data_nxt.ws_overflow  = mk_ovf_r;
      end
      default: out_data_nxt.out_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.plan_now = '{rel: (rel_n != '0), a: a_v, b: b_v, mk: mk_v};
  assign sts.plan_r   = '{rel: (rel_n_r != '0), a: a_v_r, b: b_v_r, mk: mk_v_r};
  assign sts.idx_last = ((CNT_W'(idx_r) + CNT_W'(1)) == rel_n_r);
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

/* rtl/command_line_splitter_unit.sv */
// Results: an accepted byte's plan is registered, then each result is loaded
// into the output register in turn once it is free; held whitespace released
// first takes a hold buffer read, then an output load, per entry. The next
// byte is accepted only in idle, once every result of the last byte is loaded.
// Reset: synchronous; clears parse state and output valid, not the hold buffer.
// ----------------------------------------------------------------------------
// command_line_splitter_unit: script text to command bytes
// Splits byte-serial script text into trimmed commands with end markers.
// ----------------------------------------------------------------------------
module command_line_splitter_unit
  import cls_pkg::*;
#(
  parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  text_in_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output cmd_out_t out_data
);

  cls_cmd_t    cmd;
  cls_status_t sts;

  cls_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  cls_datapath #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: command line splitter unit
// Random valid/stall traffic on both channels. Script text is built mostly
// from command-shaped fragments. Each result beat is checked in order against
// a behavioral predictor of the splitter.
// ----------------------------------------------------------------------------
module testbench;
  import cls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD       = HOLD_DEPTH_DEF;
  localparam int RAND_ITEMS = 250;
  localparam int CYCLE_CAP  = 1000000;
  localparam int HOLD_OFF   = 300;

  typedef struct {
    text_in_t beat;
    int       gap;
    bit       drain;
  } text_item_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  text_in_t in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cmd_out_t out_data;

  command_line_splitter_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  text_item_t text_q[$];
  cmd_out_t   cmd_exp_q[$];
  cmd_out_t   step_q[$];

  int  tx_mode;
  bit  drain_next;
  bit  rx_hold = 1'b0;
  int  rx_wait;
  bit  nxt_valid;
  int  n_err;
  int  n_text;
  int  n_cmd_bytes;
  int  n_marks;
  int  n_ovf_marks;
  int  n_cycles;

  // splitter state as predicted
  logic       sp_quote;
  logic       sp_comment;
  logic       sp_slash;
  logic       sp_open;
  logic       sp_ovf;
  logic [7:0] sp_held [HOLD];
  int         sp_cnt;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void put_cmd(logic [7:0] b, logic done, logic ovf);
    cmd_out_t r;
    r.out_byte     = b;
    r.command_done = done;
    r.ws_overflow  = ovf;
    r.run_last     = 1'b0;
    step_q.insert(step_q.size(), r);
  endfunction

  function automatic void end_command();
    if (sp_open) put_cmd(8'h00, 1'b1, sp_ovf);
    sp_open = 1'b0;
    sp_cnt  = 0;
    sp_ovf  = 1'b0;
  endfunction

  // trailing-candidate whitespace is parked until a real byte shows up
  function automatic void take_byte(logic [7:0] c);
    if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
      if (sp_open) begin
        if (sp_cnt < HOLD) begin
          sp_held[sp_cnt] = c;
          sp_cnt++;
        end else begin
          sp_ovf = 1'b1;
        end
      end
    end else begin
      if (sp_open) begin
        for (int i = 0; i < sp_cnt; i++) put_cmd(sp_held[i], 1'b0, 1'b0);
      end
      sp_cnt = 0;
      put_cmd(c, 1'b0, 1'b0);
      sp_open = 1'b1;
    end
  endfunction

  function automatic void plain_char(logic [7:0] c, logic last);
    if (!sp_quote && c == CH_SLASH) begin
      if (last) take_byte(c);
      else sp_slash = 1'b1;
    end else if (c == CH_QUOTE) begin
      sp_quote = !sp_quote;
      take_byte(c);
    end else if (!sp_quote && (c == CH_SEMI || c == CH_NL)) begin
      end_command();
    end else if (c != CH_CR) begin
      take_byte(c);
    end
  endfunction

  function automatic void split_text(text_in_t t);
    step_q.delete();
    if (sp_comment) begin
      if (t.text_byte == CH_NL) begin
        sp_comment = 1'b0;
        end_command();
      end
    end else if (sp_slash) begin
      sp_slash = 1'b0;
      if (t.text_byte == CH_SLASH) begin
        sp_comment = 1'b1;
      end else begin
        take_byte(CH_SLASH);
        plain_char(t.text_byte, t.text_end);
      end
    end else begin
      plain_char(t.text_byte, t.text_end);
    end
    if (t.text_end) begin
      end_command();
      sp_quote   = 1'b0;
      sp_comment = 1'b0;
      sp_slash   = 1'b0;
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].run_last = 1'b1;
    foreach (step_q[i]) cmd_exp_q.insert(cmd_exp_q.size(), step_q[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int draw_wait(int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 16)) : 0;
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic void add_char(logic [7:0] c);
    text_item_t s;
    s.beat.text_byte = c;
    s.beat.text_end  = 1'b0;
    s.gap            = draw_wait(tx_mode);
    s.drain          = drain_next;
    drain_next       = 1'b0;
    text_q.insert(text_q.size(), s);
  endfunction

  function automatic void end_text();
    if (text_q.size() > 0) text_q[text_q.size() - 1].beat.text_end = 1'b1;
  endfunction

  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 8'("a" + $urandom_range(0, 25));
      6, 7: return 8'("0" + $urandom_range(0, 9));
      8: return 8'($urandom_range(128, 255));
      default: return 8'("=");
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic void add_fragment();
    int n;
    case ($urandom_range(0, 23))
      8, 9, 10: begin
        n = $urandom_range(1, 3);
        repeat (n) add_char(blank_char());
      end
      11: begin
        // whitespace run around the hold buffer size
        n = $urandom_range(HOLD - 2, HOLD + 8);
        repeat (n) add_char(blank_char());
      end
      12, 13: add_char(CH_SEMI);
      14: add_char(CH_NL);
      15, 16: begin
        add_char(CH_QUOTE);
        n = $urandom_range(0, 5);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: add_char(CH_SEMI);
            1: add_char(CH_NL);
            2: add_char(CH_SLASH);
            3: add_char(CH_SPACE);
            default: add_char(word_char());
          endcase
        end
        add_char(CH_QUOTE);
      end
      17: begin
        add_char(CH_SLASH);
        add_char(CH_SLASH);
        n = $urandom_range(0, 4);
        repeat (n) add_char($urandom_range(0, 4) == 0 ? CH_CR : word_char());
        add_char(CH_NL);
      end
      18: begin
        add_char(CH_SLASH);
        add_char(word_char());
      end
      19, 20: begin
        n = $urandom_range(1, 3);
        repeat (n) add_char(8'($urandom_range(0, 255)));
      end
      21: end_text();
      22: begin
        add_char(CH_CR);
        add_char(CH_NL);
      end
      default: begin
        n = $urandom_range(1, 6);
        repeat (n) add_char(word_char());
      end
    endcase
  endfunction

  initial begin
    int n_dir;
    int frag;

    tx_mode    = 2;
    drain_next = 1'b0;

    // byte extremes, with a held space between them
    add_char(8'h00); add_char(CH_SPACE); add_char(8'hFF); add_char(CH_SEMI);
    // separators and a newline inside quotes
    add_char(CH_QUOTE); add_char(CH_SEMI); add_char(CH_NL); add_char(CH_QUOTE);
    add_char(CH_NL);
    // comment closes the open command, carriage return swallowed by it
    add_char("k"); add_char(CH_SLASH); add_char(CH_SLASH); add_char(CH_CR);
    add_char(CH_NL);
    // lone slash, then a slash as the last byte of the text
    add_char("a"); add_char(CH_SLASH); add_char("b"); add_char(CH_TAB);
    add_char(CH_SLASH); end_text();
    // text ends inside quotes, then inside a comment
    add_char(CH_QUOTE); add_char("q"); end_text();
    add_char("m"); add_char(CH_SLASH); add_char(CH_SLASH); end_text();
    // whitespace and carriage return only: nothing to emit
    add_char(CH_SPACE); add_char(CH_CR); add_char(CH_SEMI);

    n_dir = text_q.size();
    frag  = 0;
    while (text_q.size() < n_dir + RAND_ITEMS) begin
      frag++;
      tx_mode = (frag / 12) % 3;
      if (frag == 1 || frag == 60) drain_next = 1'b1;
      add_fragment();
    end
    end_text();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (text_q.size() != 0 || in_valid || cmd_exp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (cmd_exp_q.size() != 0) begin
      $display("%0d expected result beats never arrived", cmd_exp_q.size());
      n_err += cmd_exp_q.size();
    end
    $display("Sent %0d text bytes; got %0d command bytes and %0d end markers",
             n_text, n_cmd_bytes, n_marks);
    $display("%0d end markers flagged a dropped whitespace run", n_ovf_marks);
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver holds off long enough for the splitter to back up into its input
  initial begin
    wait (n_text >= 120);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_OFF) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      sp_quote   = 1'b0;
      sp_comment = 1'b0;
      sp_slash   = 1'b0;
      sp_open    = 1'b0;
      sp_ovf     = 1'b0;
      sp_cnt     = 0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        split_text(in_data);
        n_text++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && text_q.size() > 0) begin
        if (text_q[0].gap > 0) begin
          text_q[0].gap--;
        end else if (!(text_q[0].drain && cmd_exp_q.size() != 0)) begin
          in_data   <= text_q[0].beat;
          nxt_valid = 1'b1;
          void'(text_q.pop_front());
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    cmd_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (out_data.command_done) n_marks++;
        else n_cmd_bytes++;
        if (out_data.ws_overflow) n_ovf_marks++;
        if (cmd_exp_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("[%0t] unexpected beat: byte %h done %b ovf %b last %b", $realtime,
                     out_data.out_byte, out_data.command_done, out_data.ws_overflow,
                     out_data.run_last);
        end else begin
          want = cmd_exp_q.pop_front();
          if (out_data.out_byte !== want.out_byte ||
              out_data.command_done !== want.command_done ||
              out_data.ws_overflow !== want.ws_overflow ||
              out_data.run_last !== want.run_last) begin
            n_err++;
            if (n_err <= 10)
              $display("[%0t] beat mismatch: exp byte %h done %b ovf %b last %b, got %h %b %b %b",
                       $realtime, want.out_byte, want.command_done, want.ws_overflow,
                       want.run_last, out_data.out_byte, out_data.command_done,
                       out_data.ws_overflow, out_data.run_last);
          end
        end
        rx_wait = draw_wait(((n_cmd_bytes + n_marks) / 50) % 3);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= rx_hold || (rx_wait > 0);
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", n_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
